// ===== src/utl_pkg.sv =====
package utl_pkg;

	localparam int SRC_W      = 8;
	localparam int CP_W       = 21;
	localparam int TOK_CHAR_W = 16;
	localparam int CHAR_POS_W = 6;
	localparam int TOK_LEN_W  = 7;
	localparam int REASON_W   = 2;
	localparam int OUT_W      = TOK_CHAR_W + CHAR_POS_W + TOK_LEN_W + REASON_W + 1;

	// why a token ended
	localparam logic [REASON_W-1:0] REASON_SEP = 2'd0;
	localparam logic [REASON_W-1:0] REASON_EOI = 2'd1;
	localparam logic [REASON_W-1:0] REASON_ESC = 2'd2;
	localparam logic [REASON_W-1:0] REASON_BAD = 2'd3;

	localparam logic [SRC_W-1:0] BYTE_ESC = 8'h1b;

	localparam logic [TOK_CHAR_W-1:0] CH_0     = 16'h0030;
	localparam logic [TOK_CHAR_W-1:0] CH_9     = 16'h0039;
	localparam logic [TOK_CHAR_W-1:0] CH_LC_A  = 16'h0061;
	localparam logic [TOK_CHAR_W-1:0] CH_LC_F  = 16'h0066;
	localparam logic [TOK_CHAR_W-1:0] CH_UC_A  = 16'h0041;
	localparam logic [TOK_CHAR_W-1:0] CH_UC_F  = 16'h0046;
	localparam logic [TOK_CHAR_W-1:0] CH_COMMA = 16'h002c;

	localparam int N_ESC = 7;
	localparam logic [7:0] ESC_KEY [N_ESC] = '{8'h61, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, 8'h76};
	localparam logic [7:0] ESC_VAL [N_ESC] = '{8'h07, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b};

	typedef struct packed {
		logic                  chr_ok;
		logic [CP_W-1:0]       chr;
		logic                  stop;
		logic [REASON_W-1:0]   reason;
		logic [1:0]            pending;
		logic [CP_W-1:0]       accum;
	} dec_t;

	// bit 16 set when the character names a control escape
	function automatic logic [TOK_CHAR_W:0] esc_map(input logic [CP_W-1:0] c);
		logic [TOK_CHAR_W:0] r;
		r = '0;
		for (int i = 0; i < N_ESC; i++) begin
			if (c == CP_W'(ESC_KEY[i])) begin
				r = {1'b1, TOK_CHAR_W'(ESC_VAL[i])};
			end
		end
		return r;
	endfunction

	function automatic logic [4:0] hex_val(input logic [TOK_CHAR_W-1:0] v);
		logic [4:0] r;
		r = '0;
		if (v >= CH_0 && v <= CH_9) begin
			r = {1'b1, v[3:0]};
		end else if ((v >= CH_LC_A && v <= CH_LC_F) || (v >= CH_UC_A && v <= CH_UC_F)) begin
			r = {1'b1, v[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [TOK_CHAR_W-1:0] hex_pair(input logic [TOK_CHAR_W-1:0] h1,
		input logic [TOK_CHAR_W-1:0] h2);
		logic [4:0] d1;
		logic [4:0] d2;
		logic [TOK_CHAR_W-1:0] r;
		d1 = hex_val(h1);
		d2 = hex_val(h2);
		if (!d1[4]) begin
			r = '0;
		end else if (!d2[4]) begin
			r = TOK_CHAR_W'(d1[3:0]);
		end else begin
			r = TOK_CHAR_W'({d1[3:0], d2[3:0]});
		end
		return r;
	endfunction

endpackage

// ===== src/utl_utf8_dec.sv =====
module utl_utf8_dec (
	input  logic [1:0]                   pending,
	input  logic [utl_pkg::CP_W-1:0]     accum,
	input  logic [utl_pkg::SRC_W-1:0]    src_byte,
	output utl_pkg::dec_t                dec
);

	logic [utl_pkg::CP_W-1:0] acc_sh;

	assign acc_sh = {accum[utl_pkg::CP_W-7:0], src_byte[5:0]};

	always_comb begin
		dec         = '0;
		dec.pending = pending;
		dec.accum   = accum;
		dec.reason  = utl_pkg::REASON_BAD;
		if (pending == 2'd0) begin
			if (src_byte == utl_pkg::BYTE_ESC) begin
				dec.stop   = 1'b1;
				dec.reason = utl_pkg::REASON_ESC;
			end else if (!src_byte[7]) begin
				dec.chr_ok = 1'b1;
				dec.chr    = utl_pkg::CP_W'(src_byte);
			end else if (src_byte[7:5] == 3'b110) begin
				dec.pending = 2'd1;
				dec.accum   = utl_pkg::CP_W'(src_byte[4:0]);
			end else if (src_byte[7:4] == 4'b1110) begin
				dec.pending = 2'd2;
				dec.accum   = utl_pkg::CP_W'(src_byte[3:0]);
			end else if (src_byte[7:3] == 5'b11110) begin
				dec.pending = 2'd3;
				dec.accum   = utl_pkg::CP_W'(src_byte[2:0]);
			end else begin
				dec.stop = 1'b1;
			end
		end else if (src_byte[7:6] != 2'b10) begin
			dec.stop = 1'b1;
		end else begin
			dec.pending = pending - 2'd1;
			if (pending == 2'd1) begin
				dec.chr_ok = 1'b1;
				dec.chr    = acc_sh;
				dec.accum  = '0;
			end else begin
				dec.accum = acc_sh;
			end
		end
	end

endmodule

// ===== src/utf8_token_lexer.sv =====
// Lexer for a UTF-8 byte stream. Each input item is one source byte (tuser low) or an end of
// input mark (tuser high); bytes are decoded and split into whitespace separated tokens, with
// /* */ and // comments skipped, comma-ended tokens dropped and quoted constants unescaped.
// A source byte is taken every cycle while no token is being emitted. When a token ends, its
// characters (or a single empty result) leave one per cycle while the output keeps up, each
// carrying its position, the token length, the end reason and the overflow flag, tlast on
// the final one; the input is held while the token is read out, and longer when the output
// stalls, since the token memory has a single emission read port.
// The output register lets the next bytes be taken while the last result still waits.
// Characters beyond TOKEN_MAX are dropped and flagged.
module utf8_token_lexer #(
	parameter int TOKEN_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [utl_pkg::SRC_W-1:0]     s_axis_tdata,  // src_byte
	input  logic                          s_axis_tuser,  // kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tok_char, char_pos, tok_length, end_reason, overflowed
	output logic [utl_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                          m_axis_tlast   // is_last
);

	localparam int AW  = $clog2(TOKEN_MAX);
	localparam int WPW = $clog2(TOKEN_MAX + 1);
	localparam int CW  = utl_pkg::CP_W;
	localparam int TW  = utl_pkg::TOK_CHAR_W;

	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_BLOCK = 3'd1;
	localparam logic [2:0] MODE_LINE  = 3'd2;
	localparam logic [2:0] MODE_QUOTE = 3'd3;
	localparam logic [2:0] MODE_ESC   = 3'd4;
	localparam logic [2:0] MODE_HEX1  = 3'd5;
	localparam logic [2:0] MODE_HEX2  = 3'd6;

	localparam logic [CW-1:0] CH_SLASH = 21'h2f;
	localparam logic [CW-1:0] CH_STAR  = 21'h2a;
	localparam logic [CW-1:0] CH_SQ    = 21'h27;
	localparam logic [CW-1:0] CH_DQ    = 21'h22;
	localparam logic [CW-1:0] CH_SPACE = 21'h20;
	localparam logic [CW-1:0] CH_CR    = 21'h0d;
	localparam logic [CW-1:0] CH_LF    = 21'h0a;
	localparam logic [CW-1:0] CH_BSL   = 21'h5c;
	localparam logic [CW-1:0] CH_X     = 21'h78;

	// lexer state
	logic [2:0]     mode_q, mode_d;
	logic [CW-1:0]  rem_q, rem_d;
	logic [WPW-1:0] wp_q, wp_d;
	logic [1:0]     pend_q, pend_d;
	logic [CW-1:0]  acc_q, acc_d;
	logic           ovf_q, ovf_d;

	logic [TW-1:0]  store_mem [TOKEN_MAX];
	logic [TW-1:0]  lk_data_q;
	logic [TW-1:0]  lk_byp_q;
	logic           lk_hit_q;
	logic [TW-1:0]  last_char;

	logic           in_acc;
	utl_pkg::dec_t  dec;
	logic [TW-1:0]  c16;
	logic [TW:0]    esc;
	logic           wp_below;
	logic [WPW-1:0] wp_qm1;
	logic [WPW-1:0] wp_dm1;
	logic [AW-1:0]  lk_addr;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [TW-1:0]  wdata;
	logic           term;
	logic [utl_pkg::REASON_W-1:0] reason;
	logic           step_adv;
	logic           step_ret;
	logic           drop;

	// emission
	logic           em_active_q;
	logic [WPW-1:0] em_k_q;
	logic [WPW-1:0] em_len_q;
	logic [utl_pkg::REASON_W-1:0] em_reason_q;
	logic           em_ovf_q;
	logic           em_last;
	logic           issue;

	logic           valid_s1;
	logic [WPW-1:0] pos_s1;
	logic [WPW-1:0] len_s1;
	logic           last_s1;
	logic           empty_s1;
	logic [utl_pkg::REASON_W-1:0] reason_s1;
	logic           ovf_s1;
	logic [TW-1:0]  rd_s1;

	logic           out_valid_q;
	logic [utl_pkg::OUT_W-1:0] out_data_q;
	logic           out_last_q;
	logic           out_adv;

	utl_utf8_dec u_dec (
		.pending  (pend_q),
		.accum    (acc_q),
		.src_byte (s_axis_tdata),
		.dec      (dec)
	);

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !em_active_q;
	assign c16           = dec.chr[TW-1:0];
	assign esc           = utl_pkg::esc_map(dec.chr);
	assign wp_below      = wp_q < WPW'(TOKEN_MAX);
	assign wp_qm1        = wp_q - WPW'(1);
	assign wp_dm1        = wp_d - WPW'(1);
	assign lk_addr       = wp_dm1[AW-1:0];
	// the entry just below the write position, with the write of the last cycle bypassed
	assign last_char     = lk_hit_q ? lk_byp_q : lk_data_q;

	always_comb begin
		mode_d   = mode_q;
		rem_d    = rem_q;
		wp_d     = wp_q;
		pend_d   = pend_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		we       = 1'b0;
		waddr    = wp_q[AW-1:0];
		wdata    = c16;
		term     = 1'b0;
		reason   = utl_pkg::REASON_SEP;
		step_adv = 1'b0;
		step_ret = 1'b0;
		drop     = 1'b0;
		if (in_acc) begin
			if (s_axis_tuser) begin
				term   = 1'b1;
				reason = utl_pkg::REASON_EOI;
			end else if (dec.stop) begin
				term   = 1'b1;
				reason = dec.reason;
			end else begin
				pend_d = dec.pending;
				acc_d  = dec.accum;
				if (dec.chr_ok) begin
					we = wp_below;
					unique case (mode_q)
						MODE_PLAIN: begin
							if (dec.chr == CH_SLASH || dec.chr == CH_STAR) begin
								if (rem_q == CH_SLASH) begin
									rem_d    = '0;
									mode_d   = (dec.chr == CH_STAR) ? MODE_BLOCK : MODE_LINE;
									step_ret = 1'b1;
								end else begin
									rem_d    = dec.chr;
									step_adv = 1'b1;
								end
							end else if (dec.chr == CH_SQ || dec.chr == CH_DQ) begin
								if (wp_q == '0) begin
									rem_d  = dec.chr;
									mode_d = MODE_QUOTE;
								end
								step_adv = 1'b1;
							end else if (dec.chr <= CH_SPACE) begin
								if (wp_q != '0) begin
									if (last_char == utl_pkg::CH_COMMA) begin
										drop = 1'b1;
									end else begin
										term = 1'b1;
									end
								end
							end else begin
								step_adv = 1'b1;
							end
						end
						MODE_BLOCK: begin
							if (rem_q == CH_STAR && dec.chr == CH_SLASH) begin
								mode_d = MODE_PLAIN;
							end else begin
								rem_d = dec.chr;
							end
						end
						MODE_LINE: begin
							if (dec.chr == CH_CR || dec.chr == CH_LF) begin
								mode_d = MODE_PLAIN;
							end
						end
						MODE_QUOTE: begin
							if (dec.chr == CH_BSL) begin
								mode_d = MODE_ESC;
							end else if (dec.chr == rem_q) begin
								term = 1'b1;
							end else begin
								step_adv = 1'b1;
							end
						end
						MODE_ESC: begin
							if (dec.chr == CH_X) begin
								mode_d = MODE_HEX1;
							end else begin
								if (esc[TW]) begin
									wdata = esc[TW-1:0];
								end
								step_adv = 1'b1;
								mode_d   = MODE_QUOTE;
							end
						end
						MODE_HEX1: begin
							step_adv = 1'b1;
							mode_d   = MODE_HEX2;
						end
						default: begin
							// second hex digit: rewrite the first digit's entry, position unchanged
							we     = 1'b1;
							waddr  = wp_qm1[AW-1:0];
							wdata  = utl_pkg::hex_pair(last_char, c16);
							mode_d = MODE_QUOTE;
						end
					endcase
				end
			end
		end
		if (step_adv) begin
			if (wp_below) begin
				wp_d = wp_q + WPW'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end else if (step_ret && wp_q != '0) begin
			wp_d = wp_qm1;
		end
		if (drop) begin
			rem_d = '0;
			wp_d  = '0;
			ovf_d = 1'b0;
		end
		if (term) begin
			we     = 1'b0;
			mode_d = MODE_PLAIN;
			rem_d  = '0;
			wp_d   = '0;
			pend_d = '0;
			acc_d  = '0;
			ovf_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			rem_q  <= '0;
			wp_q   <= '0;
			pend_q <= '0;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			rem_q  <= rem_d;
			wp_q   <= wp_d;
			pend_q <= pend_d;
			acc_q  <= acc_d;
			ovf_q  <= ovf_d;
		end
	end

	// token memory: one write port, a lookup port and an emission port
	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		lk_data_q <= store_mem[lk_addr];
		lk_byp_q  <= wdata;
		if (issue) begin
			rd_s1 <= store_mem[em_k_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_hit_q <= 1'b0;
		end else begin
			lk_hit_q <= we && (waddr == lk_addr);
		end
	end

	assign out_adv = !out_valid_q || m_axis_tready;
	assign issue   = em_active_q && (!valid_s1 || out_adv);
	assign em_last = (em_len_q == '0) || (em_k_q + WPW'(1) == em_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_active_q <= 1'b0;
			em_k_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (term) begin
				em_active_q <= 1'b1;
				em_k_q      <= '0;
			end else if (issue) begin
				em_k_q <= em_k_q + WPW'(1);
				if (em_last) begin
					em_active_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// item metadata, no reset needed
	always_ff @(posedge clk) begin
		if (term) begin
			em_len_q    <= wp_q;
			em_reason_q <= reason;
			em_ovf_q    <= ovf_q;
		end
		if (issue) begin
			pos_s1    <= em_k_q;
			len_s1    <= em_len_q;
			last_s1   <= em_last;
			empty_s1  <= em_len_q == '0;
			reason_s1 <= em_reason_q;
			ovf_s1    <= em_ovf_q;
		end
		if (out_adv && valid_s1) begin
			out_data_q <= {ovf_s1, reason_s1, utl_pkg::TOK_LEN_W'(len_s1),
				utl_pkg::CHAR_POS_W'(pos_s1), empty_s1 ? TW'(0) : rd_s1};
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= WPW'(TOKEN_MAX))
		else $error("write position beyond token store");

	a_quote_wp: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q >= MODE_QUOTE) |-> (wp_q != '0))
		else $error("quoted mode without the opening quote kept");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && term) |=> (em_active_q && wp_q == '0 && pend_q == '0 && mode_q == MODE_PLAIN))
		else $error("token end did not start emission with cleared state");

	a_issue_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && em_last) |=> (!em_active_q && valid_s1))
		else $error("emission did not finish after its final item");

endmodule

// ===== tb/sv/utf8_token_lexer_tb.sv =====
`timescale 1ns / 100ps

module utf8_token_lexer_tb;

	localparam int TOKEN_MAX = 64;
	localparam int ITEMS_TOTAL = 360;

	localparam bit KIND_BYTE = 1'b0;
	localparam bit KIND_END  = 1'b1;

	localparam logic [utl_pkg::CP_W-1:0] CP_LF     = 21'h0a;
	localparam logic [utl_pkg::CP_W-1:0] CP_CR     = 21'h0d;
	localparam logic [utl_pkg::CP_W-1:0] CP_SPACE  = 21'h20;
	localparam logic [utl_pkg::CP_W-1:0] CP_DQUOTE = 21'h22;
	localparam logic [utl_pkg::CP_W-1:0] CP_SQUOTE = 21'h27;
	localparam logic [utl_pkg::CP_W-1:0] CP_STAR   = 21'h2a;
	localparam logic [utl_pkg::CP_W-1:0] CP_SLASH  = 21'h2f;
	localparam logic [utl_pkg::CP_W-1:0] CP_BSLASH = 21'h5c;
	localparam logic [utl_pkg::CP_W-1:0] CP_X      = 21'h78;

	typedef enum logic [2:0] {
		LX_PLAIN,
		LX_BLOCK,
		LX_LINE,
		LX_QUOTE,
		LX_ESCAPE,
		LX_HEX_HI,
		LX_HEX_LO
	} lex_mode_t;

	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PULSED
	} rx_pattern_t;

	// same bit order as {tlast, tdata}
	typedef struct packed {
		logic                           last;
		logic                           ovf;
		logic [utl_pkg::REASON_W-1:0]   reason;
		logic [utl_pkg::TOK_LEN_W-1:0]  len;
		logic [utl_pkg::CHAR_POS_W-1:0] pos;
		logic [utl_pkg::TOK_CHAR_W-1:0] chr;
	} tok_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [utl_pkg::SRC_W-1:0]      s_axis_tdata = '0;
	logic                           s_axis_tuser = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [utl_pkg::OUT_W-1:0]      m_axis_tdata;
	logic                           m_axis_tlast;

	// lexer state as seen by the predictor
	lex_mode_t                      lx_mode = LX_PLAIN;
	logic [utl_pkg::CP_W-1:0]       lx_prev = '0;
	logic [utl_pkg::TOK_CHAR_W-1:0] lx_store [TOKEN_MAX];
	int                             lx_wp = 0;
	int                             lx_pend = 0;
	logic [utl_pkg::CP_W-1:0]       lx_acc = '0;
	logic                           lx_ovf = 1'b0;

	tok_res_t                       token_chars_q [$];
	int                             mismatch_count = 0;
	int                             items_sent = 0;
	int                             burst_left = 0;
	rx_pattern_t                    rx_pattern = RX_OPEN;
	int                             rx_left = 0;

	utf8_token_lexer #(
		.TOKEN_MAX(TOKEN_MAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void store_char(input logic [utl_pkg::TOK_CHAR_W-1:0] v);
		if (lx_wp < TOKEN_MAX) begin
			lx_store[lx_wp] = v;
		end
	endfunction

	function automatic void wp_advance();
		if (lx_wp < TOKEN_MAX) begin
			lx_wp++;
		end else begin
			lx_ovf = 1'b1;
		end
	endfunction

	function automatic void wp_retreat();
		if (lx_wp > 0) begin
			lx_wp--;
		end
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [utl_pkg::TOK_CHAR_W-1:0] v);
		logic [utl_pkg::TOK_CHAR_W-1:0] folded;
		folded = v | 16'h0020;
		if (v >= 16'h0030 && v <= 16'h0039) begin
			return {1'b1, v[3:0]};
		end
		if (folded >= 16'h0061 && folded <= 16'h0066) begin
			return {1'b1, 4'(v[3:0] + 4'd9)};
		end
		return 5'd0;
	endfunction

	function automatic logic [utl_pkg::TOK_CHAR_W-1:0] decode_hex_pair(
		input logic [utl_pkg::TOK_CHAR_W-1:0] h1,
		input logic [utl_pkg::TOK_CHAR_W-1:0] h2);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = hex_nibble(h1);
		lo = hex_nibble(h2);
		if (!hi[4]) begin
			return '0;
		end
		if (!lo[4]) begin
			return {12'h000, hi[3:0]};
		end
		return {8'h00, hi[3:0], lo[3:0]};
	endfunction

	// one decoded character; 1 when the token is complete
	function automatic bit take_char(input logic [utl_pkg::CP_W-1:0] c);
		logic [utl_pkg::TOK_CHAR_W-1:0] c16;
		c16 = c[utl_pkg::TOK_CHAR_W-1:0];
		store_char(c16);
		case (lx_mode)
		LX_PLAIN: begin
			if (c == CP_SLASH || c == CP_STAR) begin
				if (lx_prev == CP_SLASH) begin
					lx_prev = '0;
					lx_mode = (c == CP_STAR) ? LX_BLOCK : LX_LINE;
					wp_retreat();
				end else begin
					lx_prev = c;
					wp_advance();
				end
			end else if (c == CP_SQUOTE || c == CP_DQUOTE) begin
				if (lx_wp == 0) begin
					lx_prev = c;
					lx_mode = LX_QUOTE;
				end
				wp_advance();
			end else if (c <= CP_SPACE) begin
				if (lx_wp > 0) begin
					if (lx_store[lx_wp - 1] == utl_pkg::CH_COMMA) begin
						lx_prev = '0;
						lx_wp = 0;
						lx_ovf = 1'b0;
					end else begin
						return 1'b1;
					end
				end
			end else begin
				wp_advance();
			end
		end
		LX_BLOCK: begin
			if (lx_prev == CP_STAR && c == CP_SLASH) begin
				lx_mode = LX_PLAIN;
			end else begin
				lx_prev = c;
			end
		end
		LX_LINE: begin
			if (c == CP_CR || c == CP_LF) begin
				lx_mode = LX_PLAIN;
			end
		end
		LX_QUOTE: begin
			if (c == CP_BSLASH) begin
				lx_mode = LX_ESCAPE;
			end else if (c == lx_prev) begin
				return 1'b1;
			end else begin
				wp_advance();
			end
		end
		LX_ESCAPE: begin
			if (c == CP_X) begin
				lx_mode = LX_HEX_HI;
			end else begin
				case (c)
				21'h61: store_char(16'h0007);  // a
				21'h62: store_char(16'h0008);  // b
				21'h66: store_char(16'h000c);  // f
				21'h6e: store_char(16'h000a);  // n
				21'h72: store_char(16'h000d);  // r
				21'h74: store_char(16'h0009);  // t
				21'h76: store_char(16'h000b);  // v
				default: ;
				endcase
				wp_advance();
				lx_mode = LX_QUOTE;
			end
		end
		LX_HEX_HI: begin
			wp_advance();
			lx_mode = LX_HEX_LO;
		end
		default: begin
			// first digit was kept one place back; fold both into it
			wp_retreat();
			store_char(decode_hex_pair(lx_store[lx_wp % TOKEN_MAX], c16));
			wp_advance();
			lx_mode = LX_QUOTE;
		end
		endcase
		return 1'b0;
	endfunction

	function automatic void finish_token(input logic [utl_pkg::REASON_W-1:0] why);
		int n;
		tok_res_t r;
		n = (lx_wp > TOKEN_MAX) ? TOKEN_MAX : lx_wp;
		r = '0;
		r.reason = why;
		r.ovf = lx_ovf;
		if (n == 0) begin
			r.last = 1'b1;
			token_chars_q.push_back(r);
		end
		for (int k = 0; k < n; k++) begin
			r.chr = lx_store[k];
			r.pos = 6'(k);
			r.len = 7'(n);
			r.last = (k == n - 1);
			token_chars_q.push_back(r);
		end
		lx_mode = LX_PLAIN;
		lx_prev = '0;
		lx_wp = 0;
		lx_pend = 0;
		lx_acc = '0;
		lx_ovf = 1'b0;
	endfunction

	function automatic void lex_byte(input bit kind, input logic [utl_pkg::SRC_W-1:0] b);
		logic [utl_pkg::CP_W-1:0] c;
		if (kind == KIND_END) begin
			finish_token(utl_pkg::REASON_EOI);
			return;
		end
		if (lx_pend == 0) begin
			if (b == utl_pkg::BYTE_ESC) begin
				finish_token(utl_pkg::REASON_ESC);
				return;
			end
			if (!b[7]) begin
				c = {13'h0, b};
			end else if (b[7:5] == 3'b110) begin
				lx_acc = {16'h0, b[4:0]};
				lx_pend = 1;
				return;
			end else if (b[7:4] == 4'b1110) begin
				lx_acc = {17'h0, b[3:0]};
				lx_pend = 2;
				return;
			end else if (b[7:3] == 5'b11110) begin
				lx_acc = {18'h0, b[2:0]};
				lx_pend = 3;
				return;
			end else begin
				finish_token(utl_pkg::REASON_BAD);
				return;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				finish_token(utl_pkg::REASON_BAD);
				return;
			end
			lx_acc = {lx_acc[14:0], b[5:0]};
			lx_pend--;
			if (lx_pend != 0) begin
				return;
			end
			c = lx_acc;
			lx_acc = '0;
		end
		if (take_char(c)) begin
			finish_token(utl_pkg::REASON_SEP);
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string what, input tok_res_t want, input tok_res_t seen);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected chr %h pos %0d len %0d last %0b reason %0d ovf %0b",
				want.chr, want.pos, want.len, want.last, want.reason, want.ovf);
			$display("  actual   chr %h pos %0d len %0d last %0b reason %0d ovf %0b",
				seen.chr, seen.pos, seen.len, seen.last, seen.reason, seen.ovf);
		end
	endtask

	always @(posedge clk) begin : check_results
		tok_res_t seen;
		tok_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tlast, m_axis_tdata};
			if (token_chars_q.size() == 0) begin
				want = '0;
				note_mismatch("item with nothing expected", want, seen);
			end else begin
				want = token_chars_q.pop_front();
				if (seen.chr !== want.chr || seen.pos !== want.pos || seen.len !== want.len ||
					seen.last !== want.last || seen.reason !== want.reason ||
					seen.ovf !== want.ovf) begin
					note_mismatch("token item differs", want, seen);
				end
			end
		end
	end

	// receiver back-pressure, changing its habit whenever rx_left runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_pattern)
		RX_OPEN: begin
			m_axis_tready <= 1'b1;
		end
		RX_MOSTLY: begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
		RX_SPARSE: begin
			m_axis_tready <= ($urandom_range(0, 3) == 0);
		end
		default: begin
			m_axis_tready <= rx_left[2];
		end
		endcase
	end

	// ---------------------------------------------------------------- sending

	task automatic send_item(input bit kind, input logic [utl_pkg::SRC_W-1:0] b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		burst_left--;
		items_sent++;
		lex_byte(kind, b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(KIND_BYTE, s[i]);
		end
	endtask

	// hold off until every predicted item has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (token_chars_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [utl_pkg::SRC_W-1:0] pick_letter();
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	function automatic logic [utl_pkg::SRC_W-1:0] pick_blank();
		logic [utl_pkg::SRC_W-1:0] r;
		r = 8'($urandom_range(0, 8'h20));
		if (r == utl_pkg::BYTE_ESC) begin
			r = 8'h20;
		end
		return r;
	endfunction

	// printable; slash, quotes and comma only now and then
	function automatic logic [utl_pkg::SRC_W-1:0] pick_word_byte();
		logic [utl_pkg::SRC_W-1:0] r;
		r = 8'($urandom_range(8'h21, 8'h7e));
		if ((r == 8'h2f || r == 8'h22 || r == 8'h27 || r == 8'h2c) &&
			$urandom_range(0, 9) != 0) begin
			r = 8'h5f;
		end
		return r;
	endfunction

	function automatic logic [utl_pkg::SRC_W-1:0] pick_hexish();
		string digits;
		digits = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(8'h21, 8'h7e));
		end
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [utl_pkg::SRC_W-1:0] pick_noise();
		if ($urandom_range(0, 4) < 3) begin
			return 8'($urandom_range(0, 255));
		end
		case ($urandom_range(0, 6))
		0: return utl_pkg::BYTE_ESC;
		1: return 8'h80;
		2: return 8'hbf;
		3: return 8'hc0;
		4: return 8'hf7;
		5: return 8'hf8;
		default: return 8'hff;
		endcase
	endfunction

	task automatic send_utf8_char();
		int n;
		n = $urandom_range(2, 4);
		case (n)
		2: send_item(KIND_BYTE, 8'(8'hc0 | $urandom_range(0, 31)));
		3: send_item(KIND_BYTE, 8'(8'he0 | $urandom_range(0, 15)));
		default: send_item(KIND_BYTE, 8'(8'hf0 | $urandom_range(0, 7)));
		endcase
		for (int i = 1; i < n; i++) begin
			send_item(KIND_BYTE, 8'(8'h80 | $urandom_range(0, 63)));
		end
	endtask

	task automatic send_word(input int len, input bit comma_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 6) == 0) begin
				send_utf8_char();
			end else begin
				send_item(KIND_BYTE, pick_word_byte());
			end
		end
		if (comma_end) begin
			send_item(KIND_BYTE, utl_pkg::CH_COMMA[7:0]);
		end
		send_item(KIND_BYTE, pick_blank());
	endtask

	task automatic send_escape();
		string keys;
		int pick;
		keys = "abfnrtv";
		pick = $urandom_range(0, 9);
		send_item(KIND_BYTE, CP_BSLASH[7:0]);
		if (pick < 5) begin
			send_item(KIND_BYTE, keys[$urandom_range(0, 6)]);
		end else if (pick < 8) begin
			send_item(KIND_BYTE, CP_X[7:0]);
			send_item(KIND_BYTE, pick_hexish());
			send_item(KIND_BYTE, pick_hexish());
		end else begin
			send_item(KIND_BYTE, 8'($urandom_range(8'h20, 8'h7e)));
		end
	endtask

	// a long body holds letters only and ends in a hex escape
	task automatic send_quoted(input int len, input bit long_body);
		logic [utl_pkg::SRC_W-1:0] q;
		int pick;
		q = ($urandom_range(0, 1) != 0) ? CP_SQUOTE[7:0] : CP_DQUOTE[7:0];
		send_item(KIND_BYTE, q);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			if (long_body || pick < 6) begin
				send_item(KIND_BYTE, long_body ? pick_letter() : pick_word_byte());
			end else if (pick < 9) begin
				send_escape();
			end else begin
				send_utf8_char();
			end
		end
		if (long_body) begin
			send_item(KIND_BYTE, CP_BSLASH[7:0]);
			send_item(KIND_BYTE, CP_X[7:0]);
			send_item(KIND_BYTE, pick_hexish());
			send_item(KIND_BYTE, pick_hexish());
		end
		if ($urandom_range(0, 7) != 0) begin
			send_item(KIND_BYTE, q);
		end else begin
			send_item(KIND_BYTE, pick_blank());
		end
	endtask

	task automatic send_comment(input bit block);
		logic [utl_pkg::SRC_W-1:0] b;
		send_text(block ? "/*" : "//");
		repeat ($urandom_range(0, 6)) begin
			b = 8'($urandom_range(0, 8'h7e));
			if (b == utl_pkg::BYTE_ESC ||
				(!block && (b == CP_CR[7:0] || b == CP_LF[7:0]))) begin
				b = CP_STAR[7:0];
			end
			send_item(KIND_BYTE, b);
		end
		if (block) begin
			send_text("*/");
		end else begin
			send_item(KIND_BYTE, ($urandom_range(0, 1) != 0) ? CP_LF[7:0] : CP_CR[7:0]);
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_empty_tokens();
		send_item(KIND_END, 8'h00);
		send_item(KIND_BYTE, utl_pkg::BYTE_ESC);
		drain();
	endtask

	task automatic test_separators_and_comments();
		// comma token dropped, then a line and a block comment inside one token
		send_text("a,");
		send_item(KIND_BYTE, 8'h00);
		send_text("b//\nd/**/ ");
		drain();
	endtask

	task automatic test_quoted_escapes();
		// control escape, hex escape with one digit, unknown escape
		send_text("\"\\n\\x4g\\q\"");
		drain();
	endtask

	task automatic test_utf8_and_errors();
		// two, four byte chars, then a missing continuation ends it
		send_item(KIND_BYTE, 8'hc3);
		send_item(KIND_BYTE, 8'ha9);
		send_item(KIND_BYTE, 8'hf0);
		send_item(KIND_BYTE, 8'h9f);
		send_item(KIND_BYTE, 8'h98);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_BYTE, 8'he2);
		send_item(KIND_BYTE, 8'h41);
		// end of input in the middle of a sequence
		send_item(KIND_BYTE, 8'hf0);
		send_item(KIND_BYTE, 8'h9f);
		send_item(KIND_END, 8'hff);
		// invalid lead byte
		send_item(KIND_BYTE, 8'hff);
		drain();
	endtask

	task automatic test_store_full();
		// comment opener arrives once the store is full
		repeat (66) send_item(KIND_BYTE, pick_letter());
		send_text("//x\nZ ");
		// hex escape at the full store
		send_quoted(64, 1'b1);
		// comma in the last slot, overflow, then dropped
		repeat (63) send_item(KIND_BYTE, pick_letter());
		send_item(KIND_BYTE, utl_pkg::CH_COMMA[7:0]);
		send_item(KIND_BYTE, pick_letter());
		send_text(" ok");
		send_item(KIND_END, 8'h00);
		drain();
	endtask

	task automatic test_random_text();
		int pick;
		while (items_sent < ITEMS_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_word($urandom_range(1, 8), 1'b0);
			end else if (pick < 40) begin
				send_word($urandom_range(0, 5), 1'b1);
			end else if (pick < 55) begin
				send_quoted($urandom_range(0, 6), 1'b0);
			end else if (pick < 62) begin
				send_comment(1'b1);
			end else if (pick < 68) begin
				send_comment(1'b0);
			end else if (pick < 72) begin
				repeat ($urandom_range(56, 72)) send_item(KIND_BYTE, pick_letter());
				case ($urandom_range(0, 2))
				0: send_item(KIND_BYTE, pick_blank());
				1: send_text("//\n");
				default: send_item(KIND_END, 8'($urandom_range(0, 255)));
				endcase
			end else if (pick < 75) begin
				send_quoted($urandom_range(58, 70), 1'b1);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, pick_noise());
			end else if (pick < 94) begin
				send_item(KIND_END, 8'($urandom_range(0, 255)));
			end else begin
				send_item(KIND_BYTE, utl_pkg::BYTE_ESC);
			end
		end
		drain();
	endtask

	initial begin
		foreach (lx_store[i]) begin
			lx_store[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_tokens();
		test_separators_and_comments();
		test_quoted_escapes();
		test_utf8_and_errors();
		test_store_full();
		test_random_text();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && token_chars_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== utf8_token_lexer.f =====
src/utl_pkg.sv
src/utl_utf8_dec.sv
src/utf8_token_lexer.sv
tb/sv/utf8_token_lexer_tb.sv
